>>> rtl/csm_pkg.sv
// csm_pkg: shared types and codes for the credit space manager.
// No dependencies; imported by csm_scale and credit_space_manager.
package csm_pkg;

  // command codes on in_cmd
  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_RETURN  = 2'd1;
  localparam logic [1:0] CMD_ACTIVE  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_GRANT     = 3'd0;
  localparam logic [2:0] ST_REMAINDER = 3'd1;
  localparam logic [2:0] ST_PASS      = 3'd2;
  localparam logic [2:0] ST_QUEUED    = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_RELEASED  = 3'd5;
  localparam logic [2:0] ST_DONE      = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_SPACE  = 2'd0;
  localparam logic [1:0] CFG_SPACE_RATE = 2'd1;

  localparam logic [15:0] RESET_MAX_SPACE = 16'd1024;
  localparam logic [6:0]  RATE_FULL       = 7'd100;

  // floor(2^22 / 100), used for the reciprocal divide
  localparam logic [15:0] RECIP_100 = 16'd41943;
  localparam int          RECIP_SH  = 22;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCALE = 4'b0010,
    S_POP   = 4'b0100,
    S_EMIT  = 4'b1000
  } csm_state_t;

endpackage

>>> rtl/csm_ram.sv
// csm_ram: generic single-write, single-read RAM with a registered read.
// No dependencies.
module csm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/csm_scale.sv
// csm_scale: three-stage unit giving max(1, floor(f * rate / 100)).
// Depends on csm_pkg for the reciprocal constant.
module csm_scale
  import csm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [15:0] f_in,
  input  logic [6:0]  rate_in,
  output logic        done,
  output logic [15:0] q_out
);

  logic [2:0]  vld_r;
  logic [22:0] prod_r;
  logic [22:0] prod2_r;
  logic [15:0] qe_r;
  logic [15:0] q_r;
  logic [38:0] recip_prod;
  logic [22:0] rem;
  logic [15:0] q_fix;

  assign recip_prod = 39'(prod_r) * 39'(RECIP_100);
  assign rem        = prod2_r - 23'(qe_r * 23'd100);

  always_comb begin
    q_fix = (rem >= 23'd100) ? qe_r + 16'd1 : qe_r;
    if (q_fix == 16'd0) begin
      q_fix = 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], go};
    end
    prod_r  <= 23'(f_in) * 23'(rate_in);
    prod2_r <= prod_r;
    qe_r    <= recip_prod[RECIP_SH+15:RECIP_SH];
    q_r     <= q_fix;
  end

  assign done  = vld_r[2];
  assign q_out = q_r;

endmodule

>>> rtl/credit_space_manager.sv
// credit_space_manager: credit pool with a FIFO of blocked requesters.
// Depends on csm_pkg, csm_ram (wait queue) and csm_scale (percent scaling).
//
// A request gives its single word in the cycle after start and busy stays low, so requests
//   run one per cycle. A return updates the credit (scaled by csm_scale when space_rate is
//   non-zero), releases waiters one at a time through queue RAM reads, then gives done.
// Set-active answers done in the next cycle; deactivating first drains all waiters.
// Result words are strobed on out_valid for one cycle; the receiver cannot stall.
// Reset (synchronous, rst_n low): credit 1024, inactive, queue empty, registers at defaults.
module credit_space_manager
  import csm_pkg::*;
#(
  parameter int WAIT_DEPTH  = 16,
  parameter int CREDIT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_amount,
  input  logic        in_enable,
  input  logic [7:0]  in_requester_id,
  // result channel
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_requester_id_out,
  output logic [15:0] out_free_space,
  output logic        out_last,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // architectural state
  csm_state_t             state_r,  state_nxt;
  logic [CREDIT_BITS-1:0] free_r,   free_nxt;
  logic                   active_r, active_nxt;
  logic [IDX_W-1:0]       head_r,   head_nxt;
  logic [CNT_W-1:0]       count_r,  count_nxt;
  logic [15:0]            max_space_r;
  logic [6:0]             space_rate_r;
  // per-command context
  logic [7:0]             rid_r,     rid_nxt;
  logic                   rel_all_r, rel_all_nxt;
  // output word register
  logic                   ovld_r,  ovld_nxt;
  logic [2:0]             ost_r,   ost_nxt;
  logic [7:0]             oid_r,   oid_nxt;
  logic                   olast_r, olast_nxt;

  // queue RAM and scaling unit hookup
  logic             q_wr_en, q_rd_en;
  logic [IDX_W-1:0] q_wr_addr;
  logic [7:0]       q_rd_data;
  logic             sc_go, sc_done;
  logic [15:0]      sc_f, sc_q;

  // helpers
  logic             accept;
  logic [31:0]      free32;
  logic [32:0]      ret_sum;
  logic [15:0]      ret_clamp;
  logic [6:0]       rate_sat;
  logic [SUM_W-1:0] tail_sum, tail_wrap;
  logic             queue_full, queue_empty;
  logic             more_rel;

  assign accept      = start && (state_r == S_IDLE);
  assign busy        = (state_r != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign free32      = 32'(free_r);
  assign ret_sum     = 33'(free32) + 33'(in_amount);
  assign ret_clamp   = (ret_sum >= 33'(max_space_r)) ? max_space_r : ret_sum[15:0];
  assign rate_sat    = (space_rate_r > RATE_FULL) ? RATE_FULL : space_rate_r;
  assign queue_full  = (count_r == CNT_W'(WAIT_DEPTH));
  assign queue_empty = (count_r == '0);

  // tail slot = (head + count) mod depth; sum is below twice the depth
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_wrap = (tail_sum >= SUM_W'(WAIT_DEPTH)) ? tail_sum - SUM_W'(WAIT_DEPTH)
                                                      : tail_sum;
  assign q_wr_addr = tail_wrap[IDX_W-1:0];

  // deactivation drains everything; a return drains while credit lasts
  assign more_rel = !queue_empty && (rel_all_r || (free_r != '0));

  always_comb begin
    state_nxt   = state_r;
    free_nxt    = free_r;
    active_nxt  = active_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    rid_nxt     = rid_r;
    rel_all_nxt = rel_all_r;
    ovld_nxt    = 1'b0;
    ost_nxt     = ost_r;
    oid_nxt     = oid_r;
    olast_nxt   = olast_r;
    q_wr_en     = 1'b0;
    q_rd_en     = 1'b0;
    sc_go       = 1'b0;
    sc_f        = ret_clamp;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rid_nxt     = in_requester_id;
          rel_all_nxt = 1'b0;
          oid_nxt     = in_requester_id;
          unique case (in_cmd)
            CMD_REQUEST: begin
              ovld_nxt  = 1'b1;
              olast_nxt = 1'b1;
              priority if (!active_r) begin
                ost_nxt = ST_PASS;
              end else if (free32 >= 32'(in_amount)) begin
                free_nxt = CREDIT_BITS'(free32 - 32'(in_amount));
                ost_nxt  = ST_GRANT;
              end else if ((in_amount > 16'd1) && (free_r != '0)) begin
                free_nxt = '0;
                ost_nxt  = ST_REMAINDER;
              end else if (!queue_full) begin
                q_wr_en   = 1'b1;
                count_nxt = count_r + 1'b1;
                ost_nxt   = ST_QUEUED;
              end else begin
                ost_nxt = ST_FULL;
              end
            end
            CMD_RETURN: begin
              if (in_amount <= max_space_r) begin
                if (space_rate_r != '0) begin
                  sc_go     = 1'b1;
                  state_nxt = S_SCALE;
                end else begin
                  free_nxt  = CREDIT_BITS'(ret_clamp);
                  state_nxt = S_POP;
                end
              end else begin
                state_nxt = S_POP;
              end
            end
            CMD_ACTIVE: begin
              if (active_r && in_enable) begin
                ovld_nxt  = 1'b1;
                ost_nxt   = ST_DONE;
                olast_nxt = 1'b1;
              end else begin
                active_nxt = in_enable;
                free_nxt   = CREDIT_BITS'(max_space_r);
                if (in_enable) begin
                  ovld_nxt  = 1'b1;
                  ost_nxt   = ST_DONE;
                  olast_nxt = 1'b1;
                end else begin
                  rel_all_nxt = 1'b1;
                  state_nxt   = S_POP;
                end
              end
            end
            default: begin
              // unused command code: done only
              ovld_nxt  = 1'b1;
              ost_nxt   = ST_DONE;
              olast_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCALE: begin
        if (sc_done) begin
          free_nxt  = CREDIT_BITS'(sc_q);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (more_rel) begin
          // read head entry now, present it next cycle
          q_rd_en   = 1'b1;
          head_nxt  = (head_r == IDX_W'(WAIT_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
          if (active_r) begin
            free_nxt = free_r - 1'b1;
          end
          state_nxt = S_EMIT;
        end else begin
          ovld_nxt  = 1'b1;
          ost_nxt   = ST_DONE;
          oid_nxt   = rid_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        ovld_nxt  = 1'b1;
        ost_nxt   = ST_RELEASED;
        oid_nxt   = q_rd_data;
        olast_nxt = 1'b0;
        state_nxt = S_POP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_r       <= CREDIT_BITS'(RESET_MAX_SPACE);
      active_r     <= 1'b0;
      head_r       <= '0;
      count_r      <= '0;
      max_space_r  <= RESET_MAX_SPACE;
      space_rate_r <= '0;
      ovld_r       <= 1'b0;
      rel_all_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      free_r    <= free_nxt;
      active_r  <= active_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      ovld_r    <= ovld_nxt;
      rel_all_r <= rel_all_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MAX_SPACE:  max_space_r  <= cfg_data;
          CFG_SPACE_RATE: space_rate_r <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
    rid_r   <= rid_nxt;
    ost_r   <= ost_nxt;
    oid_r   <= oid_nxt;
    olast_r <= olast_nxt;
  end

  csm_ram #(
    .WIDTH (8),
    .DEPTH (WAIT_DEPTH)
  ) u_wait_q (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (q_wr_addr),
    .wr_data (in_requester_id),
    .rd_en   (q_rd_en),
    .rd_addr (head_r),
    .rd_data (q_rd_data)
  );

  csm_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (sc_go),
    .f_in    (sc_f),
    .rate_in (rate_sat),
    .done    (sc_done),
    .q_out   (sc_q)
  );

  // the word carries the credit as it stands once the word is out
  logic [31:0] free_out32;
  assign free_out32 = 32'(free_r);

  assign out_valid            = ovld_r;
  assign out_status           = ost_r;
  assign out_requester_id_out = oid_r;
  assign out_free_space       = free_out32[15:0];
  assign out_last             = olast_r;

  // queue occupancy never passes its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WAIT_DEPTH))
    else $error("wait queue count above depth");

  // a final word always leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final word while still busy");

  // release words only come out of the drain loop
  a_rel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_RELEASED) |-> busy && !out_last)
    else $error("release word outside drain");

  // a request answers in the next cycle with its single word
  a_req_one: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == CMD_REQUEST) |=> out_valid && out_last && !busy)
    else $error("request not answered next cycle");

  // scaling unit only finishes while waiting for it
  a_scale_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sc_done |-> (state_r == S_SCALE))
    else $error("scale result with no return pending");

endmodule
